// ----- rtl/dqt_pkg.sv -----
// Shared constants and types for the disk request queue and translator.
`default_nettype none
package dqt_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DRIVE_COUNT_DEF = 8;

  localparam int PART_COUNT = 8;
  localparam int PART_W     = 26;
  localparam int SIZE_W     = 17;
  localparam int CFG_IDX_W  = 4;

  localparam logic [PART_COUNT-1:0][PART_W-1:0] PART_RESET = {
    26'd0, 26'd0, 26'd0, 26'd0, 26'd4661520, 26'd3278800, 26'd5000, 26'd81000
  };

  localparam logic OP_REQUEST  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [15:0] CTL_IENABLE = 16'o100;
  localparam logic [15:0] CTL_GO      = 16'o1;
  localparam logic [15:0] CTL_READ    = 16'd4;
  localparam logic [15:0] CTL_WRITE   = 16'd2;
  localparam logic [15:0] FAULT_MASK  = 16'o1000 | 16'o4000 | 16'o10000;
  localparam logic [3:0]  RETRY_LIMIT = 4'd10;

  localparam int          BLK_PER_CYL = 200;
  localparam int          BLK_PER_TRK = 10;
  localparam logic [28:0] CYL_RECIP   = 29'd20972;
  localparam logic [15:0] TRK_RECIP   = 16'd205;

  typedef struct packed {
    logic [7:0]  tag;
    logic [5:0]  unit;
    logic [16:0] blk;
    logic [15:0] bytes;
    logic [15:0] bufa;
    logic [1:0]  ext;
    logic        rd;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/disk_request_queue_translate.sv -----
// Disk request queue with partition check and cylinder/track/sector translation.
//
//  channel   handshake            payload
//  request   req_valid/req_stall  opcode, request_tag, unit_minor, block_number, ...
//  result    res_valid/res_stall  kind, tag, cylinder, track, sector, ..., last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request at a time: a rejected request goes from acceptance straight to its finish (S_FIN),
// an issued command passes three steps (reciprocal multiply, remainder, reciprocal multiply) to S_CMD.
// A completion reads the queue head from the RAM before finishing or reissuing.
// Synchronous reset clears the ring pointers, busy and retry count, and reloads the partitions.
// A stalled result holds the sequencer; the next request is taken once it is idle.
`default_nettype none
module disk_request_queue_translate #(
  parameter int QUEUE_DEPTH = dqt_pkg::QUEUE_DEPTH_DEF,
  parameter int DRIVE_COUNT = dqt_pkg::DRIVE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          opcode,
  input  wire logic [7:0]                    request_tag,
  input  wire logic [5:0]                    unit_minor,
  input  wire logic [16:0]                   block_number,
  input  wire logic [15:0]                   byte_count,
  input  wire logic [15:0]                   buffer_address,
  input  wire logic [1:0]                    ext_address,
  input  wire logic                          is_read,
  input  wire logic                          error_flag,
  input  wire logic [15:0]                   drive_status,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               kind,
  output logic [7:0]                         tag,
  output logic [9:0]                         cylinder,
  output logic [4:0]                         track,
  output logic [3:0]                         sector,
  output logic [15:0]                        control_word,
  output logic [15:0]                        word_count,
  output logic [15:0]                        transfer_address,
  output logic                               failed,
  output logic                               home_seek,
  output logic                               last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dqt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dqt_pkg::PART_W-1:0]    cfg_data
);
  import dqt_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [6:0] UNIT_LIMIT = 7'(DRIVE_COUNT * 8);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_CALC_Q = 3'd2;
  localparam logic [2:0] S_CALC_R = 3'd3;
  localparam logic [2:0] S_CALC_T = 3'd4;
  localparam logic [2:0] S_CMD    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]              state;
  logic [PART_W-1:0]       partition [PART_COUNT];
  logic [PTR_W-1:0]        head;
  logic [PTR_W-1:0]        tail;
  logic [FILL_W-1:0]       fill;
  logic                    busy;
  logic [3:0]              retry_count;
  logic                    finish;
  logic                    fin_fail;
  logic                    fin_cmpl;
  logic                    home;
  entry_t                  ent;
  logic [9:0]              quo;
  logic [7:0]              rem;
  logic [9:0]              cyl;
  logic [4:0]              trk;

  logic [2:0]              part_sel;
  logic [PART_W-1:0]       part;
  logic [7:0]              sz;
  logic [17:0]             blk_end;
  logic                    req_ok;
  logic                    accept;
  logic                    out_free;
  logic                    res_load;
  logic [3:0]              retry_next;
  logic                    retry_ok;
  logic [PTR_W-1:0]        head_next;
  logic [PTR_W-1:0]        tail_next;
  logic [28:0]             quo_prod;
  logic [15:0]             trk_prod;
  logic [16:0]             cyl_base;
  logic [7:0]              trk_base;
  logic [15:0]             ctl;
  entry_t                  new_ent;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic                    ram_we;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = ((state == S_CMD) || (state == S_FIN)) && out_free;

  assign part_sel = (state == S_IDLE) ? unit_minor[2:0] : ent.unit[2:0];
  assign part     = partition[part_sel];
  assign sz       = 8'(({1'b0, byte_count} + 17'd511) >> 9);
  assign blk_end  = {1'b0, block_number} + {10'd0, sz};
  assign req_ok   = ({1'b0, unit_minor} < UNIT_LIMIT) &&
                    (blk_end < {1'b0, part[SIZE_W-1:0]}) && (fill < FILL_LIMIT);

  assign retry_next = retry_count + 4'd1;
  assign retry_ok   = error_flag && (retry_next <= RETRY_LIMIT);
  assign head_next  = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign tail_next  = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);

  assign quo_prod = {15'd0, ent.blk[16:3]} * CYL_RECIP;
  assign cyl_base = 17'(quo) * 17'(BLK_PER_CYL);
  assign trk_prod = {8'd0, rem} * TRK_RECIP;
  assign trk_base = 8'(trk) * 8'(BLK_PER_TRK);
  assign ctl = {5'd0, ent.unit[5:3], 8'd0} | {10'd0, ent.ext, 4'd0} | CTL_IENABLE | CTL_GO |
               (ent.rd ? CTL_READ : CTL_WRITE);

  assign new_ent = '{tag: request_tag, unit: unit_minor, blk: block_number,
                     bytes: byte_count, bufa: buffer_address, ext: ext_address,
                     rd: is_read};
  assign ram_we  = accept && (opcode == OP_REQUEST) && req_ok;

  dqt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(new_ent),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      busy        <= 1'b0;
      retry_count <= '0;
      finish      <= 1'b0;
      fin_fail    <= 1'b0;
      fin_cmpl    <= 1'b0;
      home        <= 1'b0;
      res_valid   <= 1'b0;
      for (int i = 0; i < PART_COUNT; i++) begin
        partition[i] <= PART_RESET[i];
      end
    end else begin
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(PART_COUNT))) begin
        partition[cfg_index[2:0]] <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == OP_REQUEST) begin
              ent <= new_ent;
              if (!req_ok) begin
                fin_fail <= 1'b1;
                fin_cmpl <= 1'b0;
                state    <= S_FIN;
              end else begin
                tail <= tail_next;
                fill <= fill + FILL_W'(1);
                if (!busy) begin
                  home  <= 1'b0;
                  state <= S_CALC_Q;
                end
              end
            end else if (busy) begin
              busy <= 1'b0;
              home <= error_flag && ((drive_status & FAULT_MASK) != 16'd0);
              if (retry_ok) begin
                retry_count <= retry_next;
                finish      <= 1'b0;
              end else begin
                retry_count <= '0;
                finish      <= 1'b1;
                fin_fail    <= error_flag;
                fin_cmpl    <= 1'b1;
              end
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ent <= entry_t'(ram_rdata);
          if (finish) begin
            head  <= head_next;
            fill  <= fill - FILL_W'(1);
            state <= S_FIN;
          end else begin
            state <= S_CALC_Q;
          end
        end
        S_CALC_Q: begin
          quo   <= quo_prod[28:19];
          state <= S_CALC_R;
        end
        S_CALC_R: begin
          rem   <= 8'(ent.blk - cyl_base);
          cyl   <= quo + {1'b0, part[PART_W-1:SIZE_W]};
          state <= S_CALC_T;
        end
        S_CALC_T: begin
          trk   <= trk_prod[15:11];
          state <= S_CMD;
        end
        S_CMD: begin
          if (out_free) begin
            kind             <= KIND_CMD;
            tag              <= ent.tag;
            cylinder         <= cyl;
            track            <= trk;
            sector           <= 4'(rem - trk_base);
            control_word     <= ctl;
            word_count       <= 16'(17'd0 - {2'd0, ent.bytes[15:1]});
            transfer_address <= ent.bufa;
            failed           <= 1'b0;
            home_seek        <= home;
            last             <= 1'b1;
            busy             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            kind             <= KIND_FINISH;
            tag              <= ent.tag;
            cylinder         <= '0;
            track            <= '0;
            sector           <= '0;
            control_word     <= '0;
            word_count       <= '0;
            transfer_address <= '0;
            failed           <= fin_fail;
            home_seek        <= 1'b0;
            last             <= !fin_cmpl || (fill == '0);
            if (fin_cmpl && (fill != '0)) begin
              finish <= 1'b0;
              home   <= 1'b0;
              state  <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dqt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
